// ===== rtl/rbcr_pkg.sv =====
// types, constants and helpers shared by the rotary embedding rotator
`timescale 1ns / 1ps
package rbcr_pkg;

   localparam logic DirForward  = 1'b0;
   localparam logic DirBackward = 1'b1;

   localparam logic [15:0] Bf16QNaN = 16'h7FC0;
   localparam logic [31:0] F32QNaN  = 32'h7FC0_0000;
   localparam logic [30:0] F32InfMag = 31'h7F80_0000;

   localparam int MagWidth = 66;
   localparam int ExpWidth = 12;

   typedef struct packed {
      logic [15:0] data_real;
      logic [15:0] data_imag;
      logic [31:0] factor_real;
      logic [31:0] factor_imag;
      logic        row_end_in;
   } req_payload_type;

   typedef struct packed {
      logic [15:0] result_real;
      logic [15:0] result_imag;
      logic        row_end_out;
   } rsp_payload_type;

   typedef struct packed {
      logic [15:0] c_data;
      logic [31:0] c_factor;
      logic [15:0] m_data;
      logic [31:0] m_factor;
      logic        m_negate;
      logic        zero_fix;
      logic        tag;
   } lane_op_type;

   typedef struct packed {
      logic                        tag;
      logic                        m_sign;
      logic                        m_nan;
      logic                        m_inf;
      logic signed [ExpWidth-1:0]  m_expo;
      logic [31:0]                 m_mag;
   } side_type;

   typedef struct packed {
      logic                        nan;
      logic                        inf;
      logic                        sign;
      logic                        zero_fix;
      logic signed [ExpWidth-1:0]  expo;
      logic [MagWidth-1:0]         mag;
      side_type                    side;
   } rnd_in_type;

   typedef struct packed {
      rnd_in_type op;
      logic [6:0] lz;
   } rnd_s1_type;

   typedef struct packed {
      logic                        nan;
      logic                        inf;
      logic                        sign;
      logic                        zero;
      logic signed [ExpWidth-1:0]  be;
      logic [MagWidth-1:0]         norm;
      side_type                    side;
   } rnd_s2_type;

   typedef struct packed {
      logic                 nan;
      logic                 inf;
      logic                 sign;
      logic                 zero;
      logic [ExpWidth-1:0]  be_eff;
      logic [23:0]          keep;
      logic                 guard;
      logic                 sticky;
      side_type             side;
   } rnd_s3_type;

   typedef struct packed {
      logic [31:0] bits;
      side_type    side;
   } rnd_out_type;

   typedef struct packed {
      logic                        nan;
      logic                        inf;
      logic                        inf_sign;
      logic                        eff_sub;
      logic                        big_sign;
      logic signed [ExpWidth-1:0]  big_expo;
      logic [31:0]                 big_mag;
      logic [31:0]                 small_mag;
      logic [6:0]                  shift;
      logic                        tag;
   } add_a_type;

   typedef struct packed {
      logic                        nan;
      logic                        inf;
      logic                        inf_sign;
      logic                        eff_sub;
      logic                        big_sign;
      logic signed [ExpWidth-1:0]  big_expo;
      logic [64:0]                 big_w;
      logic [64:0]                 small_w;
      logic                        tag;
   } add_b_type;

   typedef struct packed {
      logic [15:0] value;
      logic        tag;
   } lane_out_type;

   function automatic logic [6:0] lzc66(input logic [MagWidth-1:0] v);
      logic [6:0] cnt;
      cnt = 7'(MagWidth);
      for (int i = 0; i < MagWidth; i++) begin
         if (v[i]) begin
            cnt = 7'(MagWidth - 1 - i);
         end
      end
      return cnt;
   endfunction

endpackage

// ===== rtl/rbcr_round.sv =====
// four stage fp32 rounding unit: leading zero count, normalize, denormalize, round and pack
`timescale 1ns / 1ps
module rbcr_round (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  rbcr_pkg::rnd_in_type  in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output rbcr_pkg::rnd_out_type out_data
);

   logic s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff;
   rbcr_pkg::rnd_s1_type  s1_ff, s1_in;
   rbcr_pkg::rnd_s2_type  s2_ff, s2_in;
   rbcr_pkg::rnd_s3_type  s3_ff, s3_in;
   rbcr_pkg::rnd_out_type s4_ff, s4_in;
   logic r1, r2, r3, r4;

   logic [6:0]              rs;
   logic signed [11:0]      rs_full;
   logic [65:0]             mask;
   logic [65:0]             shifted;
   logic                    lost;
   logic                    up;
   logic [24:0]             r25;
   logic [35:0]             enc;
   logic [11:0]             be_m1;

   assign r4 = !s4_v_ff || out_ready;
   assign r3 = !s3_v_ff || r4;
   assign r2 = !s2_v_ff || r3;
   assign r1 = !s1_v_ff || r2;
   assign in_ready  = r1;
   assign out_valid = s4_v_ff;
   assign out_data  = s4_ff;

   always_comb begin
      s1_in.op = in_data;
      s1_in.lz = rbcr_pkg::lzc66(in_data.mag);
   end

   always_comb begin
      s2_in.nan  = s1_ff.op.nan;
      s2_in.inf  = s1_ff.op.inf;
      s2_in.zero = (s1_ff.op.mag == '0);
      s2_in.sign = s1_ff.op.sign
                   && !(s2_in.zero && s1_ff.op.zero_fix && !s1_ff.op.inf);
      s2_in.be   = s1_ff.op.expo + 12'sd192 - $signed({5'b0, s1_ff.lz});
      s2_in.norm = s1_ff.op.mag << s1_ff.lz;
      s2_in.side = s1_ff.op.side;
   end

   always_comb begin
      rs_full = 12'sd1 - s2_ff.be;
      if (s2_ff.be >= 12'sd1) begin
         rs = 7'd0;
      end else if (rs_full > 12'sd66) begin
         rs = 7'd66;
      end else begin
         rs = rs_full[6:0];
      end
      mask    = ~({66{1'b1}} << rs);
      lost    = |(s2_ff.norm & mask);
      shifted = s2_ff.norm >> rs;
      s3_in.nan    = s2_ff.nan;
      s3_in.inf    = s2_ff.inf;
      s3_in.sign   = s2_ff.sign;
      s3_in.zero   = s2_ff.zero;
      s3_in.be_eff = (s2_ff.be >= 12'sd1) ? s2_ff.be : 12'd1;
      s3_in.keep   = shifted[65:42];
      s3_in.guard  = shifted[41];
      s3_in.sticky = (|shifted[40:0]) || lost;
      s3_in.side   = s2_ff.side;
   end

   always_comb begin
      up    = s3_ff.guard && (s3_ff.sticky || s3_ff.keep[0]);
      r25   = {1'b0, s3_ff.keep} + {24'b0, up};
      be_m1 = s3_ff.be_eff - 12'd1;
      enc   = {1'b0, be_m1, 23'b0} + {11'b0, r25};
      s4_in.side = s3_ff.side;
      priority if (s3_ff.nan) begin
         s4_in.bits = rbcr_pkg::F32QNaN;
      end else if (s3_ff.inf || (enc >= {5'b0, 31'h7F80_0000})) begin
         s4_in.bits = {s3_ff.sign, rbcr_pkg::F32InfMag};
      end else if (s3_ff.zero) begin
         s4_in.bits = {s3_ff.sign, 31'b0};
      end else begin
         s4_in.bits = {s3_ff.sign, enc[30:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
      end else begin
         if (r1) s1_v_ff <= in_valid;
         if (r2) s2_v_ff <= s1_v_ff;
         if (r3) s3_v_ff <= s2_v_ff;
         if (r4) s4_v_ff <= s3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (r1 && in_valid) s1_ff <= s1_in;
      if (r2 && s1_v_ff) s2_ff <= s2_in;
      if (r3 && s2_v_ff) s3_ff <= s3_in;
      if (r4 && s3_v_ff) s4_ff <= s4_in;
   end

endmodule

// ===== rtl/rbcr_lane.sv =====
// one output lane: product, rounded addend, fused add, fp32 and bf16 rounding
`timescale 1ns / 1ps
module rbcr_lane (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  rbcr_pkg::lane_op_type  in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output rbcr_pkg::lane_out_type out_data
);

   logic l1_v_ff, a1_v_ff, a2_v_ff, a3_v_ff, b1_v_ff;
   rbcr_pkg::rnd_in_type   l1_ff, l1_in;
   rbcr_pkg::add_a_type    a1_ff, a1_in;
   rbcr_pkg::add_b_type    a2_ff, a2_in;
   rbcr_pkg::rnd_in_type   a3_ff, a3_in;
   rbcr_pkg::lane_out_type b1_ff, b1_in;
   logic r_l1, r_a1, r_a2, r_a3, r_b1;

   logic rc_in_ready, rc_out_valid, rs_in_ready, rs_out_valid;
   rbcr_pkg::rnd_out_type rc_out, rs_out;

   // product operand unpacking
   logic [7:0]  ce_x, me_x, ce_f, me_f;
   logic [7:0]  cs8, ms8;
   logic [23:0] cs24, ms24;
   logic [31:0] c_prod;
   logic c_xn, c_xi, c_xz, c_fn, c_fi, c_fz;
   logic m_xn, m_xi, m_xz, m_fn, m_fi, m_fz;

   // addend and sum
   logic [7:0]         ae;
   logic               a_cn, a_ci, a_cz, a_mz, m_big;
   logic signed [11:0] a_ce, d_full;
   logic [64:0]        sm_w, sm_sh, sm_mask;
   logic [66:0]        sum67;
   logic               neg;
   logic [65:0]        mag;
   logic [32:0]        bf_sum;

   assign r_b1 = !b1_v_ff || out_ready;
   assign r_a3 = !a3_v_ff || rs_in_ready;
   assign r_a2 = !a2_v_ff || r_a3;
   assign r_a1 = !a1_v_ff || r_a2;
   assign r_l1 = !l1_v_ff || rc_in_ready;
   assign in_ready  = r_l1;
   assign out_valid = b1_v_ff;
   assign out_data  = b1_ff;

   always_comb begin
      me_x = {in_data.m_data[14:7]};
      ce_x = in_data.c_data[14:7];
      ce_f = in_data.c_factor[30:23];
      me_f = in_data.m_factor[30:23];
      cs8  = {ce_x != 8'd0, in_data.c_data[6:0]};
      ms8  = {me_x != 8'd0, in_data.m_data[6:0]};
      cs24 = {ce_f != 8'd0, in_data.c_factor[22:0]};
      ms24 = {me_f != 8'd0, in_data.m_factor[22:0]};
      c_prod = cs8 * cs24;
      c_xn = (ce_x == 8'hFF) && (in_data.c_data[6:0] != 7'd0);
      c_xi = (ce_x == 8'hFF) && (in_data.c_data[6:0] == 7'd0);
      c_xz = (ce_x == 8'd0) && (in_data.c_data[6:0] == 7'd0);
      c_fn = (ce_f == 8'hFF) && (in_data.c_factor[22:0] != 23'd0);
      c_fi = (ce_f == 8'hFF) && (in_data.c_factor[22:0] == 23'd0);
      c_fz = (ce_f == 8'd0) && (in_data.c_factor[22:0] == 23'd0);
      m_xn = (me_x == 8'hFF) && (in_data.m_data[6:0] != 7'd0);
      m_xi = (me_x == 8'hFF) && (in_data.m_data[6:0] == 7'd0);
      m_xz = (me_x == 8'd0) && (in_data.m_data[6:0] == 7'd0);
      m_fn = (me_f == 8'hFF) && (in_data.m_factor[22:0] != 23'd0);
      m_fi = (me_f == 8'hFF) && (in_data.m_factor[22:0] == 23'd0);
      m_fz = (me_f == 8'd0) && (in_data.m_factor[22:0] == 23'd0);

      l1_in.nan  = c_xn || c_fn || (c_xi && c_fz) || (c_xz && c_fi);
      l1_in.inf  = !l1_in.nan && (c_xi || c_fi);
      l1_in.sign = in_data.c_data[15] ^ in_data.c_factor[31];
      l1_in.zero_fix = in_data.zero_fix;
      l1_in.expo = $signed({4'b0, (ce_x == 8'd0) ? 8'd1 : ce_x})
                 + $signed({4'b0, (ce_f == 8'd0) ? 8'd1 : ce_f}) - 12'sd284;
      l1_in.mag  = {34'b0, c_prod};
      l1_in.side.tag    = in_data.tag;
      l1_in.side.m_nan  = m_xn || m_fn || (m_xi && m_fz) || (m_xz && m_fi);
      l1_in.side.m_inf  = !l1_in.side.m_nan && (m_xi || m_fi);
      l1_in.side.m_sign = in_data.m_data[15] ^ in_data.m_factor[31] ^ in_data.m_negate;
      l1_in.side.m_expo = $signed({4'b0, (me_x == 8'd0) ? 8'd1 : me_x})
                        + $signed({4'b0, (me_f == 8'd0) ? 8'd1 : me_f}) - 12'sd284;
      l1_in.side.m_mag  = ms8 * ms24;
   end

   rbcr_round u_round_c (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (l1_v_ff),
      .in_ready  (rc_in_ready),
      .in_data   (l1_ff),
      .out_valid (rc_out_valid),
      .out_ready (r_a1),
      .out_data  (rc_out)
   );

   // operand ordering for the add
   always_comb begin
      ae   = rc_out.bits[30:23];
      a_cn = (ae == 8'hFF) && (rc_out.bits[22:0] != 23'd0);
      a_ci = (ae == 8'hFF) && (rc_out.bits[22:0] == 23'd0);
      a_cz = (ae == 8'd0) && (rc_out.bits[22:0] == 23'd0);
      a_ce = $signed({4'b0, (ae == 8'd0) ? 8'd1 : ae}) - 12'sd158;
      a_mz = (rc_out.side.m_mag == 32'd0);
      priority if (a_mz) begin
         m_big = 1'b0;
      end else if (a_cz) begin
         m_big = 1'b1;
      end else begin
         m_big = (rc_out.side.m_expo >= a_ce);
      end
      a1_in.nan = rc_out.side.m_nan || a_cn
                  || (rc_out.side.m_inf && a_ci && (rc_out.side.m_sign != rc_out.bits[31]));
      a1_in.inf = !a1_in.nan && (rc_out.side.m_inf || a_ci);
      a1_in.inf_sign = rc_out.side.m_inf ? rc_out.side.m_sign : rc_out.bits[31];
      a1_in.eff_sub  = rc_out.side.m_sign ^ rc_out.bits[31];
      a1_in.tag      = rc_out.side.tag;
      if (m_big) begin
         a1_in.big_sign  = rc_out.side.m_sign;
         a1_in.big_expo  = rc_out.side.m_expo;
         a1_in.big_mag   = rc_out.side.m_mag;
         a1_in.small_mag = {ae != 8'd0, rc_out.bits[22:0], 8'b0};
         d_full          = rc_out.side.m_expo - a_ce;
      end else begin
         a1_in.big_sign  = rc_out.bits[31];
         a1_in.big_expo  = a_ce;
         a1_in.big_mag   = {ae != 8'd0, rc_out.bits[22:0], 8'b0};
         a1_in.small_mag = rc_out.side.m_mag;
         d_full          = a_ce - rc_out.side.m_expo;
      end
      if (d_full < 12'sd0) begin
         a1_in.shift = 7'd0;
      end else if (d_full > 12'sd66) begin
         a1_in.shift = 7'd66;
      end else begin
         a1_in.shift = d_full[6:0];
      end
   end

   // alignment with sticky in the lowest bit
   always_comb begin
      sm_w    = {a1_ff.small_mag, 33'b0};
      sm_sh   = sm_w >> a1_ff.shift;
      sm_mask = ~({65{1'b1}} << a1_ff.shift);
      a2_in.nan      = a1_ff.nan;
      a2_in.inf      = a1_ff.inf;
      a2_in.inf_sign = a1_ff.inf_sign;
      a2_in.eff_sub  = a1_ff.eff_sub;
      a2_in.big_sign = a1_ff.big_sign;
      a2_in.big_expo = a1_ff.big_expo;
      a2_in.big_w    = {a1_ff.big_mag, 33'b0};
      a2_in.small_w  = {sm_sh[64:1], sm_sh[0] || (|(sm_w & sm_mask))};
      a2_in.tag      = a1_ff.tag;
   end

   // add or subtract, magnitude and sign
   always_comb begin
      if (a2_ff.eff_sub) begin
         sum67 = {2'b0, a2_ff.big_w} - {2'b0, a2_ff.small_w};
      end else begin
         sum67 = {2'b0, a2_ff.big_w} + {2'b0, a2_ff.small_w};
      end
      neg = sum67[66];
      mag = neg ? (~sum67[65:0] + 66'd1) : sum67[65:0];
      a3_in.nan      = a2_ff.nan;
      a3_in.inf      = a2_ff.inf;
      a3_in.zero_fix = 1'b0;
      a3_in.expo     = a2_ff.big_expo - 12'sd33;
      a3_in.mag      = mag;
      priority if (a2_ff.inf) begin
         a3_in.sign = a2_ff.inf_sign;
      end else if (mag == '0) begin
         a3_in.sign = a2_ff.eff_sub ? 1'b0 : a2_ff.big_sign;
      end else begin
         a3_in.sign = a2_ff.big_sign ^ neg;
      end
      a3_in.side        = '0;
      a3_in.side.tag    = a2_ff.tag;
   end

   rbcr_round u_round_s (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (a3_v_ff),
      .in_ready  (rs_in_ready),
      .in_data   (a3_ff),
      .out_valid (rs_out_valid),
      .out_ready (r_b1),
      .out_data  (rs_out)
   );

   // fp32 to bf16, nearest even
   always_comb begin
      bf_sum = {1'b0, rs_out.bits} + 33'h7FFF + {32'b0, rs_out.bits[16]};
      b1_in.tag = rs_out.side.tag;
      if ((rs_out.bits[30:23] == 8'hFF) && (rs_out.bits[22:0] != 23'd0)) begin
         b1_in.value = rbcr_pkg::Bf16QNaN;
      end else begin
         b1_in.value = bf_sum[31:16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         l1_v_ff <= 1'b0;
         a1_v_ff <= 1'b0;
         a2_v_ff <= 1'b0;
         a3_v_ff <= 1'b0;
         b1_v_ff <= 1'b0;
      end else begin
         if (r_l1) l1_v_ff <= in_valid;
         if (r_a1) a1_v_ff <= rc_out_valid;
         if (r_a2) a2_v_ff <= a1_v_ff;
         if (r_a3) a3_v_ff <= a2_v_ff;
         if (r_b1) b1_v_ff <= rs_out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (r_l1 && in_valid) l1_ff <= l1_in;
      if (r_a1 && rc_out_valid) a1_ff <= a1_in;
      if (r_a2 && a1_v_ff) a2_ff <= a2_in;
      if (r_a3 && a2_v_ff) a3_ff <= a3_in;
      if (r_b1 && rs_out_valid) b1_ff <= b1_in;
   end

endmodule

// ===== rtl/rope_bf16_complex_rotator.sv =====
// top level: control register, operand routing per direction, two lanes
`timescale 1ns / 1ps
// 13 register stages lie between the accepting edge on req and its result on rsp
// throughput: one transaction per cycle while rsp is not stalled, set by the fully pipelined lanes
// (product, four stage fp32 rounding, three stage add, rounding again, bf16)
// stalls on rsp hold every stage; empty stages still fill behind a stall
// reset clears all valid bits and sets direction to forward
module rope_bf16_complex_rotator (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  rbcr_pkg::req_payload_type req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rbcr_pkg::rsp_payload_type rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic                      csr_data
);

   logic direction_ff, direction_in;
   logic fwd;
   rbcr_pkg::lane_op_type  re_op, im_op;
   rbcr_pkg::lane_out_type re_out, im_out;
   logic re_in_ready, im_in_ready, re_out_valid, im_out_valid;

   assign csr_ready    = 1'b1;
   assign direction_in = (csr_valid && csr_ready) ? csr_data : direction_ff;
   assign fwd          = (direction_ff == rbcr_pkg::DirForward);

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= rbcr_pkg::DirForward;
      end else begin
         direction_ff <= direction_in;
      end
   end

   always_comb begin
      re_op.c_data   = req_data.data_real;
      re_op.c_factor = req_data.factor_real;
      re_op.m_data   = req_data.data_imag;
      re_op.m_factor = req_data.factor_imag;
      re_op.m_negate = fwd;
      re_op.zero_fix = fwd;
      re_op.tag      = req_data.row_end_in;
      im_op.m_negate = !fwd;
      im_op.zero_fix = fwd;
      im_op.tag      = req_data.row_end_in;
      if (fwd) begin
         im_op.c_data   = req_data.data_real;
         im_op.c_factor = req_data.factor_imag;
         im_op.m_data   = req_data.data_imag;
         im_op.m_factor = req_data.factor_real;
      end else begin
         im_op.c_data   = req_data.data_imag;
         im_op.c_factor = req_data.factor_real;
         im_op.m_data   = req_data.data_real;
         im_op.m_factor = req_data.factor_imag;
      end
   end

   rbcr_lane u_lane_re (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (re_in_ready),
      .in_data   (re_op),
      .out_valid (re_out_valid),
      .out_ready (rsp_ready),
      .out_data  (re_out)
   );

   rbcr_lane u_lane_im (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (im_in_ready),
      .in_data   (im_op),
      .out_valid (im_out_valid),
      .out_ready (rsp_ready),
      .out_data  (im_out)
   );

   assign req_ready = re_in_ready;
   assign rsp_valid = re_out_valid;
   assign rsp_data.result_real = re_out.value;
   assign rsp_data.result_imag = im_out.value;
   assign rsp_data.row_end_out = re_out.tag;

   lanes_ready_agree: assert property (@(posedge clock) disable iff (reset)
      re_in_ready == im_in_ready)
      else $error("lane ready mismatch");

   lanes_valid_agree: assert property (@(posedge clock) disable iff (reset)
      re_out_valid == im_out_valid)
      else $error("lane valid mismatch");

   lanes_tag_agree: assert property (@(posedge clock) disable iff (reset)
      re_out_valid |-> (re_out.tag == im_out.tag))
      else $error("row end flag differs between lanes");

   direction_holds: assert property (@(posedge clock) disable iff (reset)
      !(csr_valid && csr_ready) |=> $stable(direction_ff))
      else $error("direction changed without a write");

endmodule

// ===== sim/tb_rope_bf16_complex_rotator.sv =====
// testbench for the bf16 rotary embedding rotator: directed and random traffic checked against a float predictor
`timescale 1ns / 1ps
module tb_rope_bf16_complex_rotator;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   rbcr_pkg::req_payload_type req_data;
   logic                      rsp_valid;
   logic                      rsp_ready;
   rbcr_pkg::rsp_payload_type rsp_data;
   logic                      csr_valid;
   logic                      csr_ready;
   logic                      csr_data;

   rbcr_pkg::req_payload_type pair_q[$];
   rbcr_pkg::rsp_payload_type rotated_q[$];
   logic            cur_direction;
   int              error_count;
   int              sent_count;
   int              checked_count;
   int              req_gap;
   int              rsp_gap;

   rope_bf16_complex_rotator DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // fp32 bit pattern to an exact real
   function automatic real f32_value(input logic [31:0] b);
      int  ex;
      real m;
      if (b[30:23] == 8'hFF) begin
         if (b[22:0] != 0) begin
            return $bitstoreal(64'h7FF8_0000_0000_0000);
         end
         return $bitstoreal({b[31], 63'h7FF0_0000_0000_0000});
      end
      ex = (b[30:23] == 0) ? 1 : int'(b[30:23]);
      m = (b[30:23] == 0) ? real'(b[22:0]) : real'({1'b1, b[22:0]});
      m = m * (2.0 ** (ex - 150));
      return b[31] ? -m : m;
   endfunction

   // real to fp32 with round to nearest even, subnormals kept
   function automatic logic [31:0] f32_round(input real d);
      logic [63:0] db;
      logic [63:0] sig;
      logic [63:0] q;
      logic [63:0] rem;
      logic [63:0] half;
      int          e;
      int          sh;
      db = $realtobits(d);
      if (db[62:52] == 11'h7FF) begin
         if (db[51:0] != 0) begin
            return rbcr_pkg::F32QNaN;
         end
         return {db[63], rbcr_pkg::F32InfMag};
      end
      sig = {11'd0, db[62:52] != 0, db[51:0]};
      e = (db[62:52] == 0) ? -1022 : int'(db[62:52]) - 1023;
      if (e > 127) begin
         return {db[63], rbcr_pkg::F32InfMag};
      end
      sh = (e >= -126) ? 29 : 29 + (-126 - e);
      if (sh >= 60) begin
         return {db[63], 31'd0};
      end
      q = sig >> sh;
      rem = sig & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && q[0])) begin
         q = q + 1;
      end
      if (e < -126) begin
         return {db[63], q[30:0]};
      end
      return {db[63], 31'((64'(e + 126) << 23) + q)};
   endfunction

   function automatic logic is_finite(input real d);
      logic [63:0] db;
      db = $realtobits(d);
      return db[62:52] != 11'h7FF;
   endfunction

   // single rounding a*b+c: exact product, sum rounded to odd, then to fp32
   function automatic logic [31:0] fused_mac(input real a, input real b, input real c);
      real         p;
      real         s;
      real         bv;
      real         err;
      logic [63:0] sb;
      p = a * b;
      s = p + c;
      if (is_finite(s) && is_finite(p) && is_finite(c)) begin
         bv = s - p;
         err = (p - (s - bv)) + (c - bv);
         if (err != 0.0 && s != 0.0) begin
            sb = $realtobits(s);
            if ((err > 0.0) != (s > 0.0)) begin
               sb = sb - 1;
            end
            sb[0] = 1'b1;
            s = $bitstoreal(sb);
         end
      end
      return f32_round(s);
   endfunction

   function automatic logic [15:0] to_bf16(input logic [31:0] u);
      logic [31:0] t;
      if (u[30:23] == 8'hFF && u[22:0] != 0) begin
         return rbcr_pkg::Bf16QNaN;
      end
      t = u + 32'h7FFF + {31'd0, u[16]};
      return t[31:16];
   endfunction

   function automatic rbcr_pkg::rsp_payload_type rotate_pair(
         input rbcr_pkg::req_payload_type p, input logic dir);
      rbcr_pkg::rsp_payload_type r;
      real             xr;
      real             xi;
      real             fr;
      real             fi;
      logic [31:0]     re;
      logic [31:0]     im;
      xr = f32_value({p.data_real, 16'd0});
      xi = f32_value({p.data_imag, 16'd0});
      fr = f32_value(p.factor_real);
      fi = f32_value(p.factor_imag);
      if (dir == rbcr_pkg::DirForward) begin
         re = fused_mac(-xi, fi, f32_value(fused_mac(xr, fr, 0.0)));
         im = fused_mac(xi, fr, f32_value(fused_mac(xr, fi, 0.0)));
      end else begin
         re = fused_mac(xi, fi, f32_value(f32_round(xr * fr)));
         im = fused_mac(-xr, fi, f32_value(f32_round(xi * fr)));
      end
      r.result_real = to_bf16(re);
      r.result_imag = to_bf16(im);
      r.row_end_out = p.row_end_in;
      return r;
   endfunction

   function automatic int draw_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [15:0] rand_bf16();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return {1'($urandom), 8'($urandom_range(110, 145)), 7'($urandom)};
      if (r < 75) return 16'($urandom);
      if (r < 85) return {1'($urandom), 8'd0, 7'($urandom)};
      case ($urandom_range(0, 4))
         0: return {1'($urandom), 15'h0000};
         1: return {1'($urandom), 15'h7F80};
         2: return {1'($urandom), 8'hFF, 7'($urandom_range(1, 127))};
         3: return {1'($urandom), 15'h7F7F};
         default: return {1'($urandom), 8'($urandom_range(240, 254)), 7'($urandom)};
      endcase
   endfunction

   function automatic logic [31:0] rand_f32();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return {1'($urandom), 8'($urandom_range(115, 127)), 23'($urandom)};
      if (r < 75) return $urandom;
      if (r < 85) return {1'($urandom), 8'd0, 23'($urandom)};
      case ($urandom_range(0, 4))
         0: return {1'($urandom), 31'h0000_0000};
         1: return {1'($urandom), rbcr_pkg::F32InfMag};
         2: return {1'($urandom), 8'hFF, 23'($urandom_range(1, 32'h7F_FFFF))};
         3: return {1'($urandom), 31'h3F80_0000};
         default: return {1'($urandom), 8'($urandom_range(200, 254)), 23'($urandom)};
      endcase
   endfunction

   function automatic rbcr_pkg::req_payload_type make_pair(
         input logic [15:0] dr, input logic [15:0] di,
         input logic [31:0] fr, input logic [31:0] fi,
         input logic re);
      rbcr_pkg::req_payload_type p;
      p.data_real = dr;
      p.data_imag = di;
      p.factor_real = fr;
      p.factor_imag = fi;
      p.row_end_in = re;
      return p;
   endfunction

   task automatic load_directed();
      pair_q.push_back(make_pair(16'h0000, 16'h8000, 32'h0000_0000, 32'h8000_0000, 1'b0));
      pair_q.push_back(make_pair(16'h3F80, 16'h0000, 32'h3F80_0000, 32'h0000_0000, 1'b1));
      pair_q.push_back(make_pair(16'h3F80, 16'h3F80, 32'h3F35_04F3, 32'h3F35_04F3, 1'b0));
      pair_q.push_back(make_pair(16'h7F7F, 16'hFF7F, 32'h3F80_0000, 32'h3F80_0000, 1'b1));
      pair_q.push_back(make_pair(16'h7F7F, 16'h7F7F, 32'h7F7F_FFFF, 32'hFF7F_FFFF, 1'b0));
      pair_q.push_back(make_pair(16'h7F80, 16'h3F80, 32'h0000_0000, 32'h3F80_0000, 1'b0));
      pair_q.push_back(make_pair(16'h7F80, 16'hFF80, 32'h3F80_0000, 32'h3F80_0000, 1'b1));
      pair_q.push_back(make_pair(16'h7FC1, 16'h3F80, 32'h3F80_0000, 32'h0000_0000, 1'b0));
      pair_q.push_back(make_pair(16'h3F80, 16'h4000, 32'h7FC0_0001, 32'h7F80_0000, 1'b0));
      pair_q.push_back(make_pair(16'h0001, 16'h807F, 32'h3F80_0000, 32'h3F00_0000, 1'b1));
      pair_q.push_back(make_pair(16'h0080, 16'h0001, 32'h3E80_0000, 32'h0000_0001, 1'b0));
      pair_q.push_back(make_pair(16'h3F81, 16'h3F80, 32'h3F80_0001, 32'h337F_FFFF, 1'b0));
      pair_q.push_back(make_pair(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
      pair_q.push_back(make_pair(16'h4049, 16'hC049, 32'h007F_FFFF, 32'h8080_0000, 1'b0));
      pair_q.push_back(make_pair(16'h5555, 16'hAAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1));
   endtask

   task automatic load_random(input int count);
      repeat (count) begin
         pair_q.push_back(make_pair(rand_bf16(), rand_bf16(), rand_f32(), rand_f32(),
                                    1'($urandom_range(0, 7) == 0)));
      end
   endtask

   task automatic write_direction(input logic v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      while (pair_q.size() != 0 || req_valid || rotated_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // track the register at its handshake
   always @(posedge clock) begin
      if (reset) begin
         cur_direction <= rbcr_pkg::DirForward;
      end else if (csr_valid && csr_ready) begin
         cur_direction <= csr_data;
      end
   end

   // request driver
   always @(posedge clock) begin
      logic nxt_valid;
      nxt_valid = req_valid;
      if (reset) begin
         nxt_valid = 1'b0;
         req_gap <= 0;
      end else begin
         if (req_valid && req_ready) begin
            rotated_q.push_back(rotate_pair(req_data, cur_direction));
            sent_count <= sent_count + 1;
            nxt_valid = 1'b0;
         end
         if (!nxt_valid) begin
            if (req_gap > 0) begin
               req_gap <= req_gap - 1;
            end else if (pair_q.size() != 0) begin
               req_data <= pair_q.pop_front();
               nxt_valid = 1'b1;
               req_gap <= draw_gap();
            end
         end
      end
      req_valid <= nxt_valid;
   end

   // response monitor
   always @(posedge clock) begin
      rbcr_pkg::rsp_payload_type exp_r;
      int bad;
      bad = 0;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_gap <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (rotated_q.size() == 0) begin
               $error("unexpected transaction: %h", rsp_data);
               bad = bad + 1;
            end else begin
               exp_r = rotated_q.pop_front();
               checked_count <= checked_count + 1;
               if (rsp_data.result_real !== exp_r.result_real) begin
                  $error("result_real expected %h actual %h", exp_r.result_real,
                         rsp_data.result_real);
                  bad = bad + 1;
               end
               if (rsp_data.result_imag !== exp_r.result_imag) begin
                  $error("result_imag expected %h actual %h", exp_r.result_imag,
                         rsp_data.result_imag);
                  bad = bad + 1;
               end
               if (rsp_data.row_end_out !== exp_r.row_end_out) begin
                  $error("row_end_out expected %b actual %b", exp_r.row_end_out,
                         rsp_data.row_end_out);
                  bad = bad + 1;
               end
            end
            if (bad != 0) begin
               error_count <= error_count + bad;
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_gap <= draw_gap();
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_data = 1'b0;
      error_count = 0;
      sent_count = 0;
      checked_count = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      write_direction(rbcr_pkg::DirForward);
      load_directed();
      load_random(400);
      drain();
      write_direction(rbcr_pkg::DirBackward);
      load_directed();
      load_random(400);
      drain();
      write_direction(rbcr_pkg::DirBackward);
      load_random(400);
      drain();
      write_direction(rbcr_pkg::DirForward);
      load_random(400);
      drain();
      $display("%0d transactions sent, %0d results checked over both directions",
               sent_count, checked_count);
      $display("including zeros, infinities, NaNs, subnormals and overflow cases");
      if (error_count == 0) begin
         $display("tb_rope_bf16_complex_rotator OK");
      end else begin
         $display("tb_rope_bf16_complex_rotator NOT OK");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("tb_rope_bf16_complex_rotator NOT OK");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/rbcr_pkg.sv
rtl/rbcr_round.sv
rtl/rbcr_lane.sv
rtl/rope_bf16_complex_rotator.sv
sim/tb_rope_bf16_complex_rotator.sv
